// ----- rtl/lmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmr_pkg: shared types and constants for the learning message router
// Message, result and route entry formats, sequencer states, register codes.
// ----------------------------------------------------------------------------
package lmr_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CHAN_BITS    = (NUM_CHANNELS >= 4) ? 4 : NUM_CHANNELS;
  localparam logic [3:0] CHAN_LIMIT = 4'((32'd1 << CHAN_BITS) - 32'd1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_SYSTEM    = 2'd0,
    CFG_OWN_COMPONENT = 2'd1,
    CFG_ACTIVE_CHANS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] in_port;
    logic [7:0] src_system;
    logic [7:0] src_component;
    logic       is_heartbeat;
    logic       has_target_system;
    logic [7:0] target_system_id;
    logic       has_target_component;
    logic [7:0] target_component_id;
    logic [3:0] room_mask;
  } msg_t;

  typedef struct packed {
    logic [3:0] send_mask;
    logic       routed;
    logic       learned;
  } result_t;

  typedef struct packed {
    logic [7:0] sys;
    logic [7:0] comp;
    logic [1:0] chan;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

  // per-entry compare outcome
  typedef struct packed {
    logic       exact;
    logic [3:0] hit_bit;
  } match_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_FIN  = 2'd2
  } state_t;

endpackage

// ----- rtl/learning_message_router.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learning_message_router: learning forwarding table for message headers
// An accepted message is scanned against every held route, and its result is
// registered in the finish state; a stalled earlier result holds it there.
// No new message is taken until that result is issued; one route
// entry is read per cycle from the table RAM through a single compare unit.
// Reset: synchronous; clears the route count and loads the default IDs
// (system 1, component 1, all channels active). No clearing pass.
// ----------------------------------------------------------------------------
module learning_message_router
  import lmr_pkg::*;
#(
  parameter int MAX_ROUTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  msg_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W = $clog2(MAX_ROUTES + 1);

  state_t state;
  state_t state_next;

  logic [7:0]       own_system_id;
  logic [7:0]       own_component_id;
  logic [3:0]       active_channels;

  msg_t             msg;
  logic [CNT_W-1:0] route_count;
  logic [CNT_W-1:0] rd_idx;
  logic             pend;
  logic             found;
  logic [3:0]       hit_acc;
  result_t          out_data_next;

  logic             in_xfer;
  logic             rd_issue;
  logic             fin_go;
  logic             learn;
  logic             sys_ok;
  logic             comp_ok;
  route_t           rd_entry;
  match_t           match;

  lmr_ram #(
    .WIDTH (ROUTE_W),
    .DEPTH (MAX_ROUTES)
  ) u_table (
    .clk     (clk),
    .wr_en   (fin_go && learn),
    .wr_addr (route_count[IDX_W-1:0]),
    .wr_data ({msg.src_system, msg.src_component, msg.in_port}),
    .rd_en   (rd_issue),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  lmr_match u_match (
    .entry  (rd_entry),
    .msg    (msg),
    .result (match)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_issue   = 1'b0;
    fin_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_issue = (rd_idx < route_count);
        if (!rd_issue && !pend) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        fin_go = !out_valid || !out_stall;
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    learn   = !found && (route_count < CNT_W'(MAX_ROUTES)) &&
              !((msg.src_system == own_system_id) &&
                (msg.src_component == own_component_id));
    sys_ok  = !msg.has_target_system || (msg.target_system_id == own_system_id);
    comp_ok = !msg.has_target_component ||
              (msg.target_component_id == own_component_id);

    out_data_next.learned = learn;
    if (msg.is_heartbeat) begin
      out_data_next.routed    = 1'b0;
      out_data_next.send_mask = active_channels & ~(4'd1 << msg.in_port) &
                                ~hit_acc & msg.room_mask & CHAN_LIMIT;
    end else if (sys_ok && comp_ok) begin
      out_data_next.routed    = 1'b0;
      out_data_next.send_mask = 4'd0;
    end else begin
      out_data_next.routed    = 1'b1;
      out_data_next.send_mask = (msg.has_target_system && msg.has_target_component) ?
                                (hit_acc & msg.room_mask & CHAN_LIMIT) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_system_id    <= 8'd1;
      own_component_id <= 8'd1;
      active_channels  <= 4'hF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_SYSTEM:    own_system_id    <= cfg_data;
        CFG_OWN_COMPONENT: own_component_id <= cfg_data;
        CFG_ACTIVE_CHANS:  active_channels  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
      rd_idx      <= '0;
      pend        <= 1'b0;
      found       <= 1'b0;
      hit_acc     <= 4'd0;
      out_valid   <= 1'b0;
    end else begin
      if (in_xfer) begin
        rd_idx  <= '0;
        pend    <= 1'b0;
        found   <= 1'b0;
        hit_acc <= 4'd0;
      end else if (state == ST_SCAN) begin
        pend <= rd_issue;
        if (rd_issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (pend) begin
          found   <= found | match.exact;
          hit_acc <= hit_acc | match.hit_bit;
        end
      end

      if (fin_go && learn) begin
        route_count <= route_count + CNT_W'(1);
      end

      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      msg <= in_data;
    end
    if (fin_go) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ----- rtl/lmr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmr_ram #(
  parameter int WIDTH  = 18,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lmr_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmr_match: route entry compare unit
// Checks one table entry against the current message: exact source match
// for learning, and the channel bit the entry contributes to the mask.
// ----------------------------------------------------------------------------
module lmr_match
  import lmr_pkg::*;
(
  input  route_t entry,
  input  msg_t   msg,
  output match_t result
);

  logic [7:0] key_sys;
  logic [7:0] key_comp;
  logic       src_eq;
  logic       key_eq;
  logic       other_chan;

  always_comb begin
    // heartbeats look up the source, other messages the target
    key_sys    = msg.is_heartbeat ? msg.src_system    : msg.target_system_id;
    key_comp   = msg.is_heartbeat ? msg.src_component : msg.target_component_id;
    src_eq     = (entry.sys == msg.src_system) && (entry.comp == msg.src_component);
    key_eq     = (entry.sys == key_sys) && (entry.comp == key_comp);
    other_chan = (entry.chan != msg.in_port);

    result.exact   = src_eq && !other_chan;
    result.hit_bit = (key_eq && other_chan) ? (4'd1 << entry.chan) : 4'd0;
  end

endmodule
